// ===== rtl/sorted_list_insert_delete_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted list assertion macros
// Shared concurrent assertion forms for the sorted list block.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list package
// Word types, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int SLI_CAPACITY = 64;

    typedef logic signed [31:0] t_value;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_op    operation;
        t_value item_value;
    } t_in_word;

    typedef struct packed {
        t_status    status;
        logic [6:0] entries_held;
    } t_out_word;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic   shift_in;   // insert: open a gap and write the value
        logic   shift_out;  // delete: close the gap at the first equal value
        t_value value;
    } t_cell_ctl;

endpackage

// ===== rtl/sli_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry, compares it with the broadcast value and shifts with
// its neighbours.
// ----------------------------------------------------------------------------
module sli_cell (
    input  logic              i_clk,
    input  sli_pkg::t_cell_ctl i_ctl,
    input  logic              i_held,
    input  sli_pkg::t_value   i_left_value,
    input  logic              i_left_lt,
    input  sli_pkg::t_value   i_right_value,
    output sli_pkg::t_value   o_value,
    output logic              o_lt,
    output logic              o_eq
);
    import sli_pkg::*;

    t_value r_value;
    t_value n_value;

    assign o_lt = i_held && (r_value < i_ctl.value);
    assign o_eq = i_held && (r_value == i_ctl.value);

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift_in && !o_lt) begin
            // The first cell not below the value takes it; later ones move up.
            n_value = i_left_lt ? i_ctl.value : i_left_value;
        end else if (i_ctl.shift_out && i_held && !o_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/sorted_list_insert_delete.sv =====
// A word accepted into the request register is applied to the list once the output register
// is free or being emptied, and its result is registered as it is applied.
// Throughput: one word per cycle while results are taken; the whole chain of cells updates
// together. Reset (synchronous, active low) empties the list and clears the
// handshake state; the cell contents need no reset.
// ----------------------------------------------------------------------------
// Sorted insertion list
// Keeps up to CAPACITY signed values in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_macros.svh"

module sorted_list_insert_delete #(
    parameter int CAPACITY = sli_pkg::SLI_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sli_pkg::t_in_word  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sli_pkg::t_out_word o_out_data
);
    import sli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // Request register: holds the accepted word until the list can take it.
    logic      r_busy;
    t_in_word  r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic      r_out_valid;
    t_out_word r_out;

    logic      apply;
    logic      accept;
    logic      full;
    logic      found;
    logic      is_insert;
    t_cell_ctl ctl;
    t_status   status;
    logic [CW+6:0] count_ext;

    t_value    cell_value [CAPACITY];
    logic      cell_lt    [CAPACITY];
    logic [CAPACITY-1:0] cell_eq;

    // The request is applied once the output register is free or being emptied,
    // so a finished result blocks the next word from entering only while it is not taken.
    assign apply      = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy || apply;
    assign accept     = i_in_valid && o_in_ready;

    assign is_insert = (r_req.operation == OP_INSERT);
    assign full      = (r_count == CW'(CAPACITY));
    assign found     = |cell_eq;

    assign ctl.value     = r_req.item_value;
    assign ctl.shift_in  = apply && is_insert && !full;
    assign ctl.shift_out = apply && !is_insert && found;

    // Each cell knows whether it is occupied from the fill count alone.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sli_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_held       (CW'(g) < r_count),
            .i_left_value ((g == 0) ? t_value'(0) : cell_value[(g == 0) ? 0 : g - 1]),
            .i_left_lt    ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g - 1]),
            .i_right_value((g == CAPACITY - 1) ? t_value'(0)
                                               : cell_value[(g == CAPACITY - 1) ? g : g + 1]),
            .o_value      (cell_value[g]),
            .o_lt         (cell_lt[g]),
            .o_eq         (cell_eq[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctl.shift_in) begin
            n_count = r_count + 1'b1;
        end else if (ctl.shift_out) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        status = ST_DONE;
        if (is_insert && full) begin
            status = ST_FULL;
        end else if (!is_insert && !found) begin
            status = ST_NOT_FOUND;
        end
    end

    // The reported count is the low seven bits of the fill count.
    assign count_ext = {7'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (apply) begin
                r_busy <= 1'b0;
            end
            if (apply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data;
        end
        if (apply) begin
            r_out.status       <= status;
            r_out.entries_held <= count_ext[6:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SLI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "fill count above capacity")
    `SLI_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, ctl.shift_in, r_count == CW'($past(r_count) + 1'b1), "insert did not grow the list")
    `SLI_ASSERT_NEXT(a_refused_keeps, i_clk, i_rst_n, apply && (status != ST_DONE), $stable(r_count), "refused request changed the list")
    `SLI_ASSERT_NOW(a_head_ordered, i_clk, i_rst_n, r_count >= CW'(2), cell_value[0] <= cell_value[1], "head of list out of order")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion list testbench
// Drives insert and delete words into the sorted list and checks each result
// word against a shadow copy of the list kept inside the bench. A short
// scripted opening covers the extremes, duplicates, the full list and the
// empty list. A long randomised stretch follows, with idling on both sides except in its final quiet blocks.
// ----------------------------------------------------------------------------
module tb;

    import sli_pkg::*;

    localparam int     HOLD_MAX   = SLI_CAPACITY;
    localparam int     HALF_CLK   = 10;
    localparam int     STUCK_MAX  = 1000;   // cycles with no handshake on either side
    localparam int     RAND_BLOCK = 50;
    localparam int     RAND_BLKS  = 9;
    localparam int     QUIET_BLKS = 2;      // final blocks run without any idling
    localparam t_value VAL_MIN    = 32'sh8000_0000;
    localparam t_value VAL_MAX    = 32'sh7FFF_FFFF;

    // One line of the scripted opening. A row may repeat its operation, with
    // the value moving by the stride on each repeat. The result is typed in
    // only for single rows whose outcome is obvious.
    typedef struct {
        t_op        op;
        t_value     value;
        int         reps;
        int         stride;
        bit         typed;
        t_status    want_status;
        logic [6:0] want_held;
    } script_row_t;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_word   in_word   = '0;
    logic       out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_word  o_out_data;

    // Shadow of the list contents and the queue of result words still owed.
    t_value     shadow_list[$];
    t_out_word  pending_outcomes[$];

    bit         quiet      = 1'b0;
    int         err_count  = 0;
    int         stall_left = 0;
    int         stuck_for  = 0;
    int         n_insert   = 0;
    int         n_delete   = 0;
    int         n_refused  = 0;
    int         n_missed   = 0;
    int         peak_fill  = 0;
    int         n_checked  = 0;

    script_row_t script[27];

    always #HALF_CLK i_clk = ~i_clk;

    sorted_list_insert_delete dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // Applies one request to the shadow list and returns the result word the
    // block should give for it. An insert lands after every strictly smaller
    // value; a delete takes out the lowest-placed equal value.
    task automatic update_shadow_list(input t_in_word w, output t_out_word r);
        int pos;
        int hit;
        pos = 0;
        hit = -1;
        r.status = ST_DONE;
        if (w.operation == OP_INSERT) begin
            n_insert++;
            if (shadow_list.size() >= HOLD_MAX) begin
                r.status = ST_FULL;
                n_refused++;
            end else begin
                foreach (shadow_list[i]) begin
                    if (shadow_list[i] < w.item_value) pos++;
                end
                shadow_list.insert(pos, w.item_value);
            end
        end else begin
            n_delete++;
            foreach (shadow_list[i]) begin
                if (hit < 0 && shadow_list[i] == w.item_value) hit = i;
            end
            if (hit < 0) begin
                r.status = ST_NOT_FOUND;
                n_missed++;
            end else begin
                shadow_list.delete(hit);
            end
        end
        if (shadow_list.size() > peak_fill) peak_fill = shadow_list.size();
        r.entries_held = 7'(shadow_list.size());
    endtask

    // Offers one word and holds it until the block takes it. Outside the
    // quiet stretch, valid is sometimes dropped for a short burst first.
    task automatic send_word(input t_op op, input t_value v, input bit typed,
                             input t_status want_status, input logic [6:0] want_held);
        t_in_word  w;
        t_out_word predicted;
        t_out_word typed_word;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        w.operation  = op;
        w.item_value = v;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        update_shadow_list(w, predicted);
        if (typed) begin
            typed_word.status       = want_status;
            typed_word.entries_held = want_held;
            pending_outcomes.push_back(typed_word);
        end else begin
            pending_outcomes.push_back(predicted);
        end
    endtask

    // Result side: ready drops in random bursts, except in the
    // quiet stretch at the end, where it stays high.
    always @(posedge i_clk) begin
        if (quiet) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Every result word taken is compared, field by field, with the oldest
    // outstanding prediction.
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && out_ready) begin
            n_checked++;
            if (pending_outcomes.size() == 0) begin
                err_count++;
                $display("%0t: result word with none expected: status %0d held %0d",
                         $time, o_out_data.status, o_out_data.entries_held);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_out_data.status !== want.status) begin
                    err_count++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_out_data.status);
                end
                if (o_out_data.entries_held !== want.entries_held) begin
                    err_count++;
                    $display("%0t: entries held expected %0d got %0d",
                             $time, want.entries_held, o_out_data.entries_held);
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either side means
    // the block has hung.
    always @(posedge i_clk) begin
        if ((i_rst_n && in_valid && o_in_ready) || (o_out_valid && out_ready))
            stuck_for = 0;
        else
            stuck_for = stuck_for + 1;
        if (stuck_for >= STUCK_MAX) begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_MAX);
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int     pct_plan[6];
        int     ins_pct;
        int     pick;
        t_op    op;
        t_value v;

        // Scripted opening. It starts on an empty list, takes in both extremes
        // and duplicates, empties the list again, then fills it to capacity,
        // tries inserts into the full list and a miss, and drains it.
        script = '{
            '{OP_DELETE, 32'sd5,          1,  0, 1'b1, ST_NOT_FOUND, 7'd0},
            '{OP_INSERT, 32'sd0,          1,  0, 1'b1, ST_DONE,      7'd1},
            '{OP_INSERT, VAL_MAX,         1,  0, 1'b1, ST_DONE,      7'd2},
            '{OP_INSERT, VAL_MIN,         1,  0, 1'b1, ST_DONE,      7'd3},
            '{OP_INSERT, -32'sd1,         1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_INSERT, 32'sd0,          1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_INSERT, VAL_MAX,         1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, 32'sd0,          1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, 32'sd0,          1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, 32'sd0,          1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, VAL_MIN,         1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, VAL_MIN,         1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, VAL_MAX,         1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, VAL_MAX,         1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, -32'sd1,         1,  0, 1'b1, ST_DONE,      7'd0},
            '{OP_INSERT, 32'sd100, HOLD_MAX, -3, 1'b0, ST_DONE,      7'd0},
            '{OP_INSERT, 32'sd7,          1,  0, 1'b1, ST_FULL,      7'(HOLD_MAX)},
            '{OP_INSERT, VAL_MIN,         1,  0, 1'b1, ST_FULL,      7'(HOLD_MAX)},
            '{OP_DELETE, 32'sd8,          1,  0, 1'b1, ST_NOT_FOUND, 7'(HOLD_MAX)},
            '{OP_DELETE, 32'sd100, HOLD_MAX, -3, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, 32'sd100,        1,  0, 1'b1, ST_NOT_FOUND, 7'd0},
            '{OP_INSERT, VAL_MIN,         3,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, VAL_MIN,         3,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_INSERT, 32'sh5555_5555,  1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_INSERT, 32'shAAAA_AAAA,  1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, 32'sh5555_5555,  1,  0, 1'b0, ST_DONE,      7'd0},
            '{OP_DELETE, 32'shAAAA_AAAA,  1,  0, 1'b1, ST_DONE,      7'd0}
        };

        // The share of inserts swings between blocks, so the list climbs to
        // capacity, sits near it, and sinks back towards empty.
        pct_plan = '{90, 90, 50, 15, 15, 50};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                send_word(script[r].op, t_value'(script[r].value + k * script[r].stride),
                          script[r].typed && script[r].reps == 1,
                          script[r].want_status, script[r].want_held);
            end
        end

        // Randomised stretch. Deletes mostly aim at values that are held, so
        // that they hit; inserts draw heavily on a small pool so that equal
        // values pile up, with full-width values mixed in for bit coverage.
        for (int blk = 0; blk < RAND_BLKS; blk++) begin
            ins_pct = pct_plan[blk % 6];
            if (blk >= RAND_BLKS - QUIET_BLKS) quiet = 1'b1;
            for (int n = 0; n < RAND_BLOCK; n++) begin
                op   = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
                pick = $urandom_range(0, 9);
                if (op == OP_INSERT) begin
                    if (pick <= 3)
                        v = t_value'(int'($urandom_range(0, 8)) - 4);
                    else if (pick <= 5 && shadow_list.size() > 0)
                        v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
                    else if (pick == 8)
                        v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                    else
                        v = t_value'($urandom);
                end else begin
                    if (pick <= 6 && shadow_list.size() > 0)
                        v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
                    else if (pick <= 8)
                        v = t_value'(int'($urandom_range(0, 8)) - 4);
                    else
                        v = t_value'($urandom);
                end
                send_word(op, v, 1'b0, ST_DONE, 7'd0);
            end
        end
        in_valid <= 1'b0;

        // Let every owed result word arrive, then keep watching for
        // anything stray the block might still produce.
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d inserts (%0d refused on a full list) and %0d deletes (%0d misses).",
                 n_insert, n_refused, n_delete, n_missed);
        $display("Peak fill %0d of %0d, %0d result words checked, %0d mismatches.",
                 peak_fill, HOLD_MAX, n_checked, err_count);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== sorted_list_insert_delete.f =====
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sorted_list_insert_delete.sv
bench/tb.sv
